// ===== design/mbs_pkg.sv =====
// Shared types and codes for the multiset bag store.
package mbs_pkg;

    typedef enum logic [1:0] {
        OP_INSERT    = 2'd0,
        OP_ERASE_ONE = 2'd1,
        OP_ERASE_ALL = 2'd2
    } op_t;

    localparam logic [1:0] STAT_DONE   = 2'd0;
    localparam logic [1:0] STAT_FULL   = 2'd1;
    localparam logic [1:0] STAT_ABSENT = 2'd2;

    localparam int OP_W      = 2;
    localparam int IN_VAL_W  = 32;
    localparam int IN_DATA_W = 40;
    localparam int COUNT_W   = 7;
    localparam int OUT_DATA_W = 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic shift;
        logic write;
    } cell_ctrl_t;

endpackage

// ===== design/multiset_bag_store.sv =====
// Top level of the multiset bag store: a chain of entry cells and its sequencer.
// Insert writes the new entry at accept and moves to the finish state, which loads the result register;
// erase first runs a scan that passes every held entry once through the head of the cell chain.
// One request is in flight at a time: the next input transfer is accepted once the sequencer
// is back in idle, even while a result waits for transfer.
// Reset clears occupancy and the control state; entry cells are not cleared and need no pass.
module multiset_bag_store
    import mbs_pkg::*;
#(
    parameter int CAPACITY    = 64,
    parameter int VALUE_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // op[1:0], value[33:2], zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata    // status[1:0], removed[8:2], occupancy[15:9]
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    cell_ctrl_t             ctrl;
    logic [IW-1:0]          wr_idx;
    logic [VALUE_WIDTH-1:0] wr_data;
    logic [VALUE_WIDTH-1:0] in_value;
    logic [VALUE_WIDTH-1:0] cell_q [CAPACITY];
    logic [1:0]             status;
    logic [CW-1:0]          removed;
    logic [CW-1:0]          occupancy;
    logic [CW+COUNT_W-1:0]  removed_ext;
    logic [CW+COUNT_W-1:0]  occ_ext;

    assign in_value = VALUE_WIDTH'(s_tdata[OP_W +: IN_VAL_W]);

    mbs_ctrl #(
        .CAPACITY (CAPACITY),
        .VW       (VALUE_WIDTH),
        .IW       (IW),
        .CW       (CW)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_op         (s_tdata[OP_W-1:0]),
        .in_value      (in_value),
        .head          (cell_q[0]),
        .ctrl          (ctrl),
        .wr_idx        (wr_idx),
        .wr_data       (wr_data),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (status),
        .out_removed   (removed),
        .out_occupancy (occupancy)
    );

    for (genvar j = 0; j < CAPACITY; j++)
    begin : g_cell
        mbs_cell #(
            .VW  (VALUE_WIDTH),
            .IW  (IW),
            .IDX (j)
        ) u_cell (
            .clk     (clk),
            .ctrl    (ctrl),
            .wr_idx  (wr_idx),
            .wr_data (wr_data),
            .nbr     (cell_q[(j == CAPACITY - 1) ? j : j + 1]),
            .q       (cell_q[j])
        );
    end

    assign removed_ext = {{COUNT_W{1'b0}}, removed};
    assign occ_ext     = {{COUNT_W{1'b0}}, occupancy};
    assign m_tdata     = {occ_ext[COUNT_W-1:0], removed_ext[COUNT_W-1:0], status};

endmodule

// ===== design/mbs_cell.sv =====
// One storage cell of the entry chain: loads from its upper neighbor or the write bus.
module mbs_cell
    import mbs_pkg::*;
#(
    parameter int VW  = 32,
    parameter int IW  = 6,
    parameter int IDX = 0
)
(
    input  logic          clk,
    input  cell_ctrl_t    ctrl,
    input  logic [IW-1:0] wr_idx,
    input  logic [VW-1:0] wr_data,
    input  logic [VW-1:0] nbr,
    output logic [VW-1:0] q
);

    logic [VW-1:0] val_reg;
    logic [VW-1:0] val_next;

    always_comb
    begin
        val_next = val_reg;
        if (ctrl.write && (wr_idx == IW'(IDX)))
        begin
            val_next = wr_data;
        end
        else if (ctrl.shift)
        begin
            val_next = nbr;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign q = val_reg;

endmodule

// ===== design/mbs_ctrl.sv =====
// Request sequencer: insert, compacting erase scan over the cell chain, and result register.
module mbs_ctrl
    import mbs_pkg::*;
#(
    parameter int CAPACITY = 64,
    parameter int VW       = 32,
    parameter int IW       = 6,
    parameter int CW       = 7
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    in_op,
    input  logic [VW-1:0] in_value,
    input  logic [VW-1:0] head,
    output cell_ctrl_t    ctrl,
    output logic [IW-1:0] wr_idx,
    output logic [VW-1:0] wr_data,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [1:0]    out_status,
    output logic [CW-1:0] out_removed,
    output logic [CW-1:0] out_occupancy
);

    state_t        state_reg, state_next;
    logic [1:0]    op_reg, op_next;
    logic [VW-1:0] value_reg, value_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] remain_reg, remain_next;
    logic [CW-1:0] tail_reg, tail_next;
    logic [CW-1:0] removed_reg, removed_next;
    logic [1:0]    status_reg, status_next;
    logic          ovalid_reg, ovalid_next;
    logic [1:0]    ostatus_reg, ostatus_next;
    logic [CW-1:0] oremoved_reg, oremoved_next;
    logic [CW-1:0] oocc_reg, oocc_next;
    logic          accept;
    logic          drop;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign drop     = (head == value_reg)
                      && ((op_reg == OP_ERASE_ALL) || (removed_reg == '0));

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        value_next    = value_reg;
        count_next    = count_reg;
        remain_next   = remain_reg;
        tail_next     = tail_reg;
        removed_next  = removed_reg;
        status_next   = status_reg;
        ovalid_next   = ovalid_reg;
        ostatus_next  = ostatus_reg;
        oremoved_next = oremoved_reg;
        oocc_next     = oocc_reg;
        ctrl          = '0;
        wr_idx        = count_reg[IW-1:0];
        wr_data       = in_value;

        if (ovalid_reg && out_ready)
        begin
            ovalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next      = in_op;
                    value_next   = in_value;
                    remain_next  = count_reg;
                    tail_next    = count_reg;
                    removed_next = '0;
                    status_next  = STAT_DONE;
                    state_next   = S_FINISH;
                    if (in_op == OP_INSERT)
                    begin
                        if (count_reg >= CW'(CAPACITY))
                        begin
                            status_next = STAT_FULL;
                        end
                        else
                        begin
                            ctrl.write = 1'b1;
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else if ((in_op == OP_ERASE_ONE) || (in_op == OP_ERASE_ALL))
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (remain_reg == '0)
                begin
                    count_next  = tail_reg;
                    status_next = (removed_reg == '0) ? STAT_ABSENT : STAT_DONE;
                    state_next  = S_FINISH;
                end
                else
                begin
                    ctrl.shift  = 1'b1;
                    remain_next = remain_reg - 1'b1;
                    wr_data     = head;
                    wr_idx      = IW'(tail_reg - 1'b1);
                    if (drop)
                    begin
                        tail_next    = tail_reg - 1'b1;
                        removed_next = removed_reg + 1'b1;
                    end
                    else
                    begin
                        ctrl.write = 1'b1;
                    end
                end
            end
            S_FINISH:
            begin
                if (!ovalid_reg || out_ready)
                begin
                    ovalid_next   = 1'b1;
                    ostatus_next  = status_reg;
                    oremoved_next = removed_reg;
                    oocc_next     = count_reg;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        value_reg    <= value_next;
        remain_reg   <= remain_next;
        tail_reg     <= tail_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
        ostatus_reg  <= ostatus_next;
        oremoved_reg <= oremoved_next;
        oocc_reg     <= oocc_next;
    end

    assign out_valid     = ovalid_reg;
    assign out_status    = ostatus_reg;
    assign out_removed   = oremoved_reg;
    assign out_occupancy = oocc_reg;

    // The held entries plus the ones already dropped always add up to the start count.
    a_scan_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |->
        ((CW+1)'(tail_reg) + (CW+1)'(removed_reg) == (CW+1)'(count_reg)))
        else $error("scan tail and removed count disagree with occupancy");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("occupancy exceeds capacity");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (in_op == OP_INSERT) && (count_reg < CW'(CAPACITY))) |=>
        (count_reg == $past(count_reg) + 1'b1))
        else $error("insert did not grow occupancy");

    a_no_write_at_full: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.write && !ctrl.shift) |-> (count_reg < CW'(CAPACITY)))
        else $error("insert write into a full store");

endmodule
